@@ hw/rtl/abrf_pkg.sv @@
package abrf_pkg;

  // access codes of the input item
  typedef enum logic [1:0] {
    OP_READ       = 2'd0,
    OP_WRITE      = 2'd1,
    OP_READ_USER  = 2'd2,
    OP_WRITE_USER = 2'd3
  } op_t;

  // processor modes, cpsr bits 4:0
  localparam logic [4:0] MODE_USR = 5'h10;
  localparam logic [4:0] MODE_FIQ = 5'h11;
  localparam logic [4:0] MODE_IRQ = 5'h12;
  localparam logic [4:0] MODE_SVC = 5'h13;
  localparam logic [4:0] MODE_ABT = 5'h17;
  localparam logic [4:0] MODE_UND = 5'h1B;
  localparam logic [4:0] MODE_SYS = 5'h1F;

  // logical register numbers
  localparam logic [4:0] IDX_FIQ_LO = 5'd8;
  localparam logic [4:0] IDX_FIQ_HI = 5'd12;
  localparam logic [4:0] IDX_SP     = 5'd13;
  localparam logic [4:0] IDX_LR     = 5'd14;
  localparam logic [4:0] IDX_PC     = 5'd15;
  localparam logic [4:0] IDX_CPSR   = 5'd16;
  localparam logic [4:0] IDX_SPSR   = 5'd17;

  // bank sizes
  localparam int unsigned N_SHARED = 13;
  localparam int unsigned N_FIQ    = 5;
  localparam int unsigned N_SP_LR  = 6;
  localparam int unsigned N_SPSR   = 5;

  localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;
  localparam logic [31:0] UNKNOWN_READ = 32'd1;

  typedef struct packed {
    logic       ok;
    logic [2:0] idx;
  } bank_sel_t;

  // r13/r14 bank of a mode: 0 user/system, 1 fiq .. 5 undefined
  function automatic bank_sel_t sp_lr_bank(input logic [4:0] mode);
    bank_sel_t b;
    b.ok = 1'b1;
    case (mode)
      MODE_USR: b.idx = 3'd0;
      MODE_SYS: b.idx = 3'd0;
      MODE_FIQ: b.idx = 3'd1;
      MODE_IRQ: b.idx = 3'd2;
      MODE_SVC: b.idx = 3'd3;
      MODE_ABT: b.idx = 3'd4;
      MODE_UND: b.idx = 3'd5;
      default: begin
        b.ok  = 1'b0;
        b.idx = 3'd0;
      end
    endcase
    return b;
  endfunction

endpackage

@@ hw/rtl/arm_banked_register_file.sv @@
// Banked register file for an ARMv5 core. Each item reads or writes one logical
// register (r0-r15, 16 cpsr, 17 spsr), in the current mode taken from cpsr[4:0]
// or forced to the user bank. One item is accepted every clock while out_ready
// holds or no result waits; its result reaches the outputs through the input register,
// then the result register, which lets the next item be taken while a result waits.
// State updates in item order, so a cpsr write changes the mode and the
// has_spsr/privileged flags from the following item on. Unless forced to the user
// bank, reads of r13, r14 or spsr in an invalid mode, and of spsr in user or system
// mode, return all ones; numbers 18-31 read 1 and ignore writes. Registers reset to 0.
module arm_banked_register_file (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_operation,
  input  logic [4:0]  in_reg_index,
  input  logic [31:0] in_write_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_read_data,
  output logic        out_has_spsr,
  output logic        out_privileged
);
  import abrf_pkg::*;

  // input stage
  logic        s1_valid_r;
  logic [1:0]  s1_op_r;
  logic [4:0]  s1_idx_r;
  logic [31:0] s1_val_r;

  // result stage
  logic        out_valid_r;
  logic [31:0] out_data_r;
  logic        out_spsr_r;
  logic        out_priv_r;

  // register banks
  logic [31:0] shared_regs_r     [N_SHARED];
  logic [31:0] fiq_high_regs_r   [N_FIQ];
  logic [31:0] stack_ptr_bank_r  [N_SP_LR];
  logic [31:0] link_reg_bank_r   [N_SP_LR];
  logic [31:0] saved_status_r    [N_SPSR];
  logic [31:0] program_counter_r;
  logic [31:0] status_word_r;

  logic        advance;
  logic        do_access;
  logic        is_write;
  logic        user_bank;
  logic [4:0]  mode;
  logic        in_fiq;
  logic        is_fiq_range;
  logic        use_fiq;
  bank_sel_t   mode_bank;
  bank_sel_t   sp_bank;
  logic        spsr_ok;
  logic [2:0]  spsr_idx;
  logic [3:0]  shared_idx;
  logic [2:0]  fiq_idx;
  logic [31:0] rd_data;
  logic [31:0] data_nxt;
  logic        has_spsr_nxt;
  logic        priv_nxt;

  // handshake
  assign advance   = !out_valid_r || out_ready;
  assign in_ready  = !s1_valid_r || advance;
  assign do_access = s1_valid_r && advance;

  // decode of the held item
  assign is_write     = s1_op_r[0];
  assign user_bank    = s1_op_r[1];
  assign mode         = status_word_r[4:0];
  assign in_fiq       = (mode == MODE_FIQ);
  assign is_fiq_range = (s1_idx_r >= IDX_FIQ_LO) && (s1_idx_r <= IDX_FIQ_HI);
  assign use_fiq      = !user_bank && in_fiq;
  assign mode_bank    = sp_lr_bank(mode);
  assign shared_idx   = s1_idx_r[3:0];
  assign fiq_idx      = 3'(s1_idx_r - IDX_FIQ_LO);

  // r13/r14 bank, user bank when forced
  always_comb begin
    if (user_bank) begin
      sp_bank.ok  = 1'b1;
      sp_bank.idx = 3'd0;
    end else begin
      sp_bank = mode_bank;
    end
  end

  // spsr bank exists only in exception modes
  assign spsr_ok  = mode_bank.ok && (mode_bank.idx != 3'd0);
  assign spsr_idx = mode_bank.idx - 3'd1;

  // read mux
  always_comb begin
    rd_data = UNKNOWN_READ;
    if (s1_idx_r < IDX_FIQ_LO) begin
      rd_data = shared_regs_r[shared_idx];
    end else if (is_fiq_range) begin
      rd_data = use_fiq ? fiq_high_regs_r[fiq_idx] : shared_regs_r[shared_idx];
    end else if (s1_idx_r == IDX_SP || s1_idx_r == IDX_LR) begin
      if (!sp_bank.ok) begin
        rd_data = ALL_ONES;
      end else if (s1_idx_r == IDX_SP) begin
        rd_data = stack_ptr_bank_r[sp_bank.idx];
      end else begin
        rd_data = link_reg_bank_r[sp_bank.idx];
      end
    end else if (s1_idx_r == IDX_PC) begin
      rd_data = program_counter_r;
    end else if (s1_idx_r == IDX_CPSR) begin
      rd_data = status_word_r;
    end else if (s1_idx_r == IDX_SPSR && !user_bank) begin
      rd_data = spsr_ok ? saved_status_r[spsr_idx] : ALL_ONES;
    end
  end

  // result fields, flags from the mode before the access
  assign data_nxt     = is_write ? 32'd0 : rd_data;
  assign has_spsr_nxt = (mode != MODE_USR) && (mode != MODE_SYS);
  assign priv_nxt     = (mode != MODE_USR);

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_op_r  <= in_operation;
      s1_idx_r <= in_reg_index;
      s1_val_r <= in_write_value;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
    if (do_access) begin
      out_data_r <= data_nxt;
      out_spsr_r <= has_spsr_nxt;
      out_priv_r <= priv_nxt;
    end
  end

  // register bank writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N_SHARED; i++) shared_regs_r[i] <= '0;
      for (int i = 0; i < N_FIQ; i++) fiq_high_regs_r[i] <= '0;
      for (int i = 0; i < N_SP_LR; i++) begin
        stack_ptr_bank_r[i] <= '0;
        link_reg_bank_r[i]  <= '0;
      end
      for (int i = 0; i < N_SPSR; i++) saved_status_r[i] <= '0;
      program_counter_r <= '0;
      status_word_r     <= '0;
    end else if (do_access && is_write) begin
      if (s1_idx_r < IDX_FIQ_LO) begin
        shared_regs_r[shared_idx] <= s1_val_r;
      end else if (is_fiq_range) begin
        if (use_fiq) begin
          fiq_high_regs_r[fiq_idx] <= s1_val_r;
        end else begin
          shared_regs_r[shared_idx] <= s1_val_r;
        end
      end else if (s1_idx_r == IDX_SP) begin
        if (sp_bank.ok) begin
          stack_ptr_bank_r[sp_bank.idx] <= s1_val_r;
        end
      end else if (s1_idx_r == IDX_LR) begin
        if (sp_bank.ok) begin
          link_reg_bank_r[sp_bank.idx] <= s1_val_r;
        end
      end else if (s1_idx_r == IDX_PC) begin
        program_counter_r <= s1_val_r;
      end else if (s1_idx_r == IDX_CPSR) begin
        status_word_r <= s1_val_r;
      end else if (s1_idx_r == IDX_SPSR && !user_bank && spsr_ok) begin
        saved_status_r[spsr_idx] <= s1_val_r;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_data_r;
  assign out_has_spsr   = out_spsr_r;
  assign out_privileged = out_priv_r;

endmodule

@@ hw/rtl/abrf_checker.sv @@
module abrf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_read_data,
  input logic        out_has_spsr,
  input logic        out_privileged
);

  // a stalled result holds its data
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_data))
    else $error("result changed while stalled");

  // only privileged modes have an spsr
  a_spsr_priv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_privileged |-> !out_has_spsr)
    else $error("spsr flag set in user mode");

  // no result straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // an empty result stage never blocks the input
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result stage");

endmodule

bind arm_banked_register_file abrf_checker u_abrf_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_data  (out_read_data),
  .out_has_spsr   (out_has_spsr),
  .out_privileged (out_privileged)
);

@@ sim/tb_arm_banked_register_file.sv @@
module tb_arm_banked_register_file;
  timeunit 1ns;
  timeprecision 1ps;

  import abrf_pkg::*;

  localparam int unsigned STUCK_LIMIT = 300;
  localparam int unsigned N_SEGMENTS  = 50;
  localparam int unsigned SEG_ITEMS   = 26;
  localparam int unsigned CALM_SEGS   = 8;
  localparam int unsigned MAX_SHOWN   = 10;

  typedef struct {
    logic [31:0] read_data;
    logic        has_spsr;
    logic        privileged;
  } access_result_t;

  // banked register state plus the results still owed by the block
  class bank_tracker;
    logic [31:0]    gpr_low [N_SHARED];
    logic [31:0]    fiq_gpr [N_FIQ];
    logic [31:0]    sp_bank [N_SP_LR];
    logic [31:0]    lr_bank [N_SP_LR];
    logic [31:0]    spsr_bank [N_SPSR];
    logic [31:0]    pc_reg;
    logic [31:0]    status_reg;
    access_result_t expected_results [$];
    int unsigned    mismatches;

    function new();
      foreach (gpr_low[i]) gpr_low[i] = '0;
      foreach (fiq_gpr[i]) fiq_gpr[i] = '0;
      foreach (sp_bank[i]) begin
        sp_bank[i] = '0;
        lr_bank[i] = '0;
      end
      foreach (spsr_bank[i]) spsr_bank[i] = '0;
      pc_reg     = '0;
      status_reg = '0;
      mismatches = 0;
    endfunction

    // r13/r14 slot of a mode, -1 when the mode is not a real one
    function int sp_lr_slot(logic [4:0] mode);
      case (mode)
        MODE_USR, MODE_SYS: return 0;
        MODE_FIQ:           return 1;
        MODE_IRQ:           return 2;
        MODE_SVC:           return 3;
        MODE_ABT:           return 4;
        MODE_UND:           return 5;
        default:            return -1;
      endcase
    endfunction

    function void note_access(op_t op, logic [4:0] idx, logic [31:0] val);
      logic [4:0]     mode;
      bit             user;
      bit             is_write;
      int             slot;
      int             spsr_slot;
      access_result_t r;
      mode        = status_reg[4:0];
      user        = (op == OP_READ_USER || op == OP_WRITE_USER);
      is_write    = (op == OP_WRITE || op == OP_WRITE_USER);
      slot        = user ? 0 : sp_lr_slot(mode);
      spsr_slot   = sp_lr_slot(mode) - 1;
      // flags come from the mode before this access
      r.read_data  = '0;
      r.has_spsr   = (mode != MODE_USR && mode != MODE_SYS);
      r.privileged = (mode != MODE_USR);
      if (idx < IDX_FIQ_LO) begin
        if (is_write) gpr_low[idx] = val;
        else r.read_data = gpr_low[idx];
      end else if (idx <= IDX_FIQ_HI) begin
        // fiq keeps its own r8-r12
        if (!user && mode == MODE_FIQ) begin
          if (is_write) fiq_gpr[idx - IDX_FIQ_LO] = val;
          else r.read_data = fiq_gpr[idx - IDX_FIQ_LO];
        end else begin
          if (is_write) gpr_low[idx] = val;
          else r.read_data = gpr_low[idx];
        end
      end else if (idx == IDX_SP || idx == IDX_LR) begin
        if (slot < 0) begin
          if (!is_write) r.read_data = ALL_ONES;
        end else if (idx == IDX_SP) begin
          if (is_write) sp_bank[slot] = val;
          else r.read_data = sp_bank[slot];
        end else begin
          if (is_write) lr_bank[slot] = val;
          else r.read_data = lr_bank[slot];
        end
      end else if (idx == IDX_PC) begin
        if (is_write) pc_reg = val;
        else r.read_data = pc_reg;
      end else if (idx == IDX_CPSR) begin
        if (is_write) status_reg = val;
        else r.read_data = status_reg;
      end else if (idx == IDX_SPSR && !user) begin
        // no spsr in user, system or an invalid mode
        if (spsr_slot < 0) begin
          if (!is_write) r.read_data = ALL_ONES;
        end else begin
          if (is_write) spsr_bank[spsr_slot] = val;
          else r.read_data = spsr_bank[spsr_slot];
        end
      end else if (!is_write) begin
        r.read_data = UNKNOWN_READ;
      end
      expected_results.push_back(r);
    endfunction

    function void check_result(logic [31:0] data, logic has_spsr, logic privileged);
      access_result_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: data %h has_spsr %b privileged %b",
                   data, has_spsr, privileged);
        return;
      end
      want = expected_results.pop_front();
      if (data !== want.read_data || has_spsr !== want.has_spsr ||
          privileged !== want.privileged) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result mismatch: data %h/%h has_spsr %b/%b privileged %b/%b (exp/got)",
                   want.read_data, data, want.has_spsr, has_spsr,
                   want.privileged, privileged);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_operation;
  logic [4:0]  in_reg_index;
  logic [31:0] in_write_value;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_read_data;
  logic        out_has_spsr;
  logic        out_privileged;

  bank_tracker sb = new();
  int unsigned idle_pct;
  int unsigned stall_left = 0;
  int unsigned stuck_cycles = 0;

  arm_banked_register_file dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_operation   (in_operation),
    .in_reg_index   (in_reg_index),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_data  (out_read_data),
    .out_has_spsr   (out_has_spsr),
    .out_privileged (out_privileged)
  );

  always #5 clk = ~clk;

  // accepted items on both channels
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready)
      sb.note_access(op_t'(in_operation), in_reg_index, in_write_value);
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_read_data, out_has_spsr, out_privileged);
  end

  // receiver stalls in bursts, started at random when idling is enabled
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (rst_n && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 9);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("tb_arm_banked_register_file: errors");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  task automatic send_item(input op_t op, input logic [4:0] idx, input logic [31:0] val);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_operation   <= op;
    in_reg_index   <= idx;
    in_write_value <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // status word with random upper bits, mostly a real mode
  function automatic logic [31:0] mode_word(bit real_mode);
    logic [4:0]  modes [7] = '{MODE_USR, MODE_FIQ, MODE_IRQ, MODE_SVC,
                               MODE_ABT, MODE_UND, MODE_SYS};
    logic [31:0] w;
    w = $urandom();
    if (real_mode) w[4:0] = modes[$urandom_range(0, 6)];
    return w;
  endfunction

  task automatic run_segment();
    op_t         op;
    logic [4:0]  idx;
    logic [31:0] val;
    int unsigned pick;
    // open with a mode switch so banked paths get exercised
    send_item(OP_WRITE, IDX_CPSR, mode_word($urandom_range(0, 6) != 0));
    repeat (SEG_ITEMS - 1) begin
      op   = op_t'($urandom_range(0, 3));
      pick = $urandom_range(0, 99);
      if (pick < 10) idx = 5'($urandom_range(18, 31));
      else if (pick < 55) idx = 5'($urandom_range(IDX_FIQ_LO, IDX_SPSR));
      else idx = 5'($urandom_range(0, IDX_SPSR));
      pick = $urandom_range(0, 9);
      if (idx == IDX_CPSR) val = mode_word(pick < 8);
      else if (pick == 0) val = '0;
      else if (pick == 1) val = ALL_ONES;
      else val = $urandom();
      send_item(op, idx, val);
    end
  endtask

  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_operation   <= OP_READ;
    in_reg_index   <= '0;
    in_write_value <= '0;
    idle_pct       = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: invalid mode out of reset
    send_item(OP_READ,  5'd0,     '0);
    send_item(OP_READ,  IDX_SP,   '0);
    send_item(OP_WRITE, IDX_LR,   32'h1234_5678);
    send_item(OP_READ,  IDX_SPSR, '0);
    // user mode: no spsr
    send_item(OP_WRITE, IDX_CPSR, {27'h0, MODE_USR});
    send_item(OP_WRITE, 5'd0,     ALL_ONES);
    send_item(OP_WRITE, IDX_FIQ_LO, 32'hA5A5_5A5A);
    send_item(OP_WRITE, IDX_SP,   32'h0000_1000);
    send_item(OP_WRITE, IDX_SPSR, 32'hDEAD_BEEF);
    send_item(OP_READ,  IDX_SPSR, '0);
    // fiq mode: banked r8-r12, r13, r14, spsr
    send_item(OP_WRITE, IDX_CPSR, {27'h7800006, MODE_FIQ});
    send_item(OP_WRITE, IDX_FIQ_HI, 32'hFEED_F00D);
    send_item(OP_WRITE, IDX_LR,   32'h8000_0001);
    send_item(OP_WRITE, IDX_SPSR, 32'hC0DE_0013);
    send_item(OP_READ,  IDX_FIQ_LO, '0);
    send_item(OP_READ_USER,  IDX_SP,   '0);
    send_item(OP_WRITE_USER, IDX_FIQ_HI, 32'h0F0F_0F0F);
    send_item(OP_READ_USER,  IDX_SPSR, '0);
    send_item(OP_WRITE_USER, IDX_SPSR, ALL_ONES);
    send_item(OP_READ,  IDX_SPSR, '0);
    // unknown register numbers
    send_item(OP_WRITE, 5'd31, ALL_ONES);
    send_item(OP_READ,  5'd31, '0);
    send_item(OP_READ,  5'd18, '0);
    // system mode shares the user r13/r14
    send_item(OP_WRITE, IDX_CPSR, {27'h0, MODE_SYS});
    send_item(OP_WRITE, IDX_PC,   32'h0000_8000);
    send_item(OP_READ,  IDX_SP,   '0);

    // random part, idling level changes from one segment to the next
    for (int unsigned seg = 0; seg < N_SEGMENTS; seg++) begin
      if (seg >= N_SEGMENTS - CALM_SEGS) idle_pct = 0;
      else case ($urandom_range(0, 2))
        0: idle_pct = 0;
        1: idle_pct = 8;
        default: idle_pct = 30;
      endcase
      run_segment();
    end
    in_valid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("tb_arm_banked_register_file: clean");
    end else begin
      $display("tb_arm_banked_register_file: errors");
    end
    $finish;
  end

endmodule
